// File: design/qrs_pkg.sv
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [15:0] EPS_RESET = 16'd7;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_EPS = 1'b0;

    typedef logic [3:0] t_kind;

    localparam t_kind K_NONE = 4'd0;
    localparam t_kind K_INF  = 4'd1;
    localparam t_kind K_LIN  = 4'd2;
    localparam t_kind K_CZ0  = 4'd3;
    localparam t_kind K_CZ   = 4'd4;
    localparam t_kind K_SYM  = 4'd5;
    localparam t_kind K_DBL  = 4'd6;
    localparam t_kind K_TWO  = 4'd7;
    localparam t_kind K_NEG  = 4'd8;

    typedef logic [1:0] t_cnt;

    localparam t_cnt CNT_NONE = 2'd0;
    localparam t_cnt CNT_ONE  = 2'd1;
    localparam t_cnt CNT_TWO  = 2'd2;
    localparam t_cnt CNT_INF  = 2'd3;

    typedef struct packed {
        t_kind              kind;
        logic               a_neg;
        logic               neg_pre;
        logic signed [31:0] b;
        logic [32:0]        den;
        logic [31:0]        mpre;
    } t_sba;

    typedef struct packed {
        t_kind       kind;
        logic        neg1;
        logic        neg2;
        logic [31:0] sym;
        logic        sym_ovf;
    } t_sbb;

endpackage

// File: design/qrs_div.sv
module qrs_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    genvar k;
    for (k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [NUM_W-1:0] p_nq;
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   d;
        logic             ge;
        logic [DEN_W:0]   n_rem;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_nq  = i_num;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_nq  = r_nq[k-1];
            assign p_den = r_den[k-1];
        end

        assign t     = {p_rem, p_nq[NUM_W-1]};
        assign d     = {1'b0, p_den};
        assign ge    = (t >= d);
        assign n_rem = ge ? (t - d) : t;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[DEN_W-1:0];
                r_nq[k]  <= {p_nq[NUM_W-2:0], ge};
                r_den[k] <= p_den;
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule

// File: design/qrs_sqrt.sv
module qrs_sqrt #(
    parameter int W = 68
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_x,
    output logic [W/2-1:0] o_root
);

    localparam int QW = W / 2;
    localparam int RW = QW + 2;

    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_root [QW];
    logic [W-1:0]  r_x    [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] p_rem;
        logic [QW-1:0] p_root;
        logic [W-1:0]  p_x;
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic          ge;
        logic [RW+1:0] n_rem;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_x;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
        end

        assign t     = {p_rem, p_x[W-1:W-2]};
        assign trial = (RW+2)'({p_root, 2'b01});
        assign ge    = (t >= trial);
        assign n_rem = ge ? (t - trial) : t;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem[RW-1:0];
                r_root[k] <= {p_root[QW-2:0], ge};
                r_x[k]    <= {p_x[W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[QW-1];

endmodule

// File: design/quadratic_root_solver.sv
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point with FRAC_BITS fraction bits.
// One item per cycle is accepted in steady state while the output is not held off. Each item
// passes through the bit-per-stage dividers and the digit-per-stage square root.
// The pipeline stalls only while a finished result waits and a new one reaches the end.
// near_zero_limit sits at address 0 and may be changed only while no item is in flight.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // coef_square [31:0], coef_linear [63:32], coef_const [95:64]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // root_count [1:0], first_root [33:2], second_root [65:34], overflow [66], zero fill
    output logic [71:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int F    = FRAC_BITS;
    localparam int MAXW = (32 + 2 * F > 67) ? 32 + 2 * F : 67;
    localparam int SW   = MAXW + (MAXW % 2);
    localparam int SQW  = SW / 2;
    localparam int SUMW = SQW + 2;
    localparam int NBW  = SUMW + F;
    localparam int DA   = SW + SQW;
    localparam int TOT  = 5 + DA + NBW;

    logic [15:0]    r_eps;
    logic [TOT-1:0] r_vld;
    logic           r_o_vld;
    logic           en;

    assign en            = !r_vld[TOT-1] || !r_o_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2:2] == qrs_pkg::REG_EPS) ? {16'b0, r_eps} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps   <= qrs_pkg::EPS_RESET;
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2:2] == qrs_pkg::REG_EPS) begin
                r_eps <= pwdata[15:0];
            end
            if (en) begin
                r_vld <= {r_vld[TOT-2:0], s_axis_tvalid};
            end
            r_o_vld <= (r_o_vld && !m_axis_tready) || (en && r_vld[TOT-1]);
        end
    end

    // stage 1: inputs
    logic signed [31:0] r1_a, r1_b, r1_c;

    // stage 2: magnitudes, near-zero tests, products
    logic [31:0] n2_ma, n2_mb, n2_mc;
    logic [31:0] r2_ma, r2_mb, r2_mc;
    logic        r2_an, r2_bn, r2_cn, r2_bz, r2_anz, r2_bnz, r2_cnz;
    logic [63:0] r2_bb, r2_ac;

    assign n2_ma = r1_a[31] ? (~r1_a + 32'd1) : r1_a;
    assign n2_mb = r1_b[31] ? (~r1_b + 32'd1) : r1_b;
    assign n2_mc = r1_c[31] ? (~r1_c + 32'd1) : r1_c;

    // stage 3: discriminant magnitude
    logic [65:0] ac4, bbx;
    logic [66:0] n3_dm;
    logic        n3_dneg;
    logic [66:0] r3_dm;
    logic        r3_dneg;
    logic [31:0] r3_ma, r3_mb, r3_mc;
    logic        r3_an, r3_bn, r3_cn, r3_bz, r3_anz, r3_bnz, r3_cnz;
    logic signed [31:0] r2_b, r3_b;

    assign ac4 = {r2_ac, 2'b00};
    assign bbx = 66'(r2_bb);

    always_comb begin
        n3_dneg = 1'b0;
        if (r2_an ^ r2_cn) begin
            n3_dm = 67'(bbx) + 67'(ac4);
        end else if (ac4 <= bbx) begin
            n3_dm = 67'(bbx - ac4);
        end else begin
            n3_dm   = 67'(ac4 - bbx);
            n3_dneg = 1'b1;
        end
    end

    // stage 4: case selection
    logic [66:0]    lim;
    logic           dnear;
    qrs_pkg::t_kind kind4;
    qrs_pkg::t_sba  n4_sb, r4_sb;
    logic [SW-1:0]  n4_num, r4_num;
    logic [31:0]    n4_den, r4_den;

    assign lim   = 67'(r_eps) << F;
    assign dnear = (r3_dm == '0) || (r3_dm < lim);

    always_comb begin
        if (r3_anz) begin
            if (!r3_bnz) begin
                kind4 = qrs_pkg::K_LIN;
            end else if (r3_cnz) begin
                kind4 = qrs_pkg::K_INF;
            end else begin
                kind4 = qrs_pkg::K_NONE;
            end
        end else if (r3_cnz) begin
            kind4 = r3_bz ? qrs_pkg::K_CZ0 : qrs_pkg::K_CZ;
        end else if (r3_bz && (r3_an ^ r3_cn)) begin
            kind4 = qrs_pkg::K_SYM;
        end else if (dnear) begin
            kind4 = qrs_pkg::K_DBL;
        end else if (!r3_dneg) begin
            kind4 = qrs_pkg::K_TWO;
        end else begin
            kind4 = qrs_pkg::K_NEG;
        end
    end

    always_comb begin
        n4_sb.kind  = kind4;
        n4_sb.a_neg = r3_an;
        n4_sb.b     = r3_b;
        n4_sb.mpre  = (kind4 == qrs_pkg::K_LIN) ? r3_mc : r3_mb;
        n4_sb.neg_pre = (kind4 == qrs_pkg::K_LIN) ? !(r3_cn ^ r3_bn) : !(r3_bn ^ r3_an);
        case (kind4)
            qrs_pkg::K_LIN: n4_sb.den = {1'b0, r3_mb};
            qrs_pkg::K_CZ:  n4_sb.den = {1'b0, r3_ma};
            qrs_pkg::K_DBL,
            qrs_pkg::K_TWO: n4_sb.den = {r3_ma, 1'b0};
            default:        n4_sb.den = 33'd1;
        endcase
        if (kind4 == qrs_pkg::K_SYM) begin
            n4_num = SW'(r3_mc) << (2 * F);
            n4_den = r3_ma;
        end else begin
            n4_num = SW'(r3_dm);
            n4_den = 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= s_axis_tdata[31:0];
            r1_b    <= s_axis_tdata[63:32];
            r1_c    <= s_axis_tdata[95:64];
            r2_ma   <= n2_ma;
            r2_mb   <= n2_mb;
            r2_mc   <= n2_mc;
            r2_b    <= r1_b;
            r2_an   <= r1_a[31];
            r2_bn   <= r1_b[31];
            r2_cn   <= r1_c[31];
            r2_bz   <= (r1_b == '0);
            r2_anz  <= (n2_ma == '0) || (n2_ma < {16'b0, r_eps});
            r2_bnz  <= (n2_mb == '0) || (n2_mb < {16'b0, r_eps});
            r2_cnz  <= (n2_mc == '0) || (n2_mc < {16'b0, r_eps});
            r2_bb   <= 64'(n2_mb) * 64'(n2_mb);
            r2_ac   <= 64'(n2_ma) * 64'(n2_mc);
            r3_dm   <= n3_dm;
            r3_dneg <= n3_dneg;
            r3_ma   <= r2_ma;
            r3_mb   <= r2_mb;
            r3_mc   <= r2_mc;
            r3_b    <= r2_b;
            r3_an   <= r2_an;
            r3_bn   <= r2_bn;
            r3_cn   <= r2_cn;
            r3_bz   <= r2_bz;
            r3_anz  <= r2_anz;
            r3_bnz  <= r2_bnz;
            r3_cnz  <= r2_cnz;
            r4_sb   <= n4_sb;
            r4_num  <= n4_num;
            r4_den  <= n4_den;
        end
    end

    // quotient for the symmetric case, pass-through of the discriminant otherwise
    logic [SW-1:0]  qa;
    logic [SQW-1:0] sq;

    qrs_div #(.NUM_W(SW), .DEN_W(32)) u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_num),
        .i_den (r4_den),
        .o_quo (qa)
    );

    qrs_sqrt #(.W(SW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (qa),
        .o_root (sq)
    );

    qrs_pkg::t_sba r_sba [DA];

    // stage 5: root numerators and signs
    qrs_pkg::t_sba      sa;
    logic signed [SUMW-1:0] sx, bx, t1, t2;
    logic [SUMW-1:0]    m1, m2;
    logic [SUMW-1:0]    n5_m1, n5_m2;
    qrs_pkg::t_sbb      n5_sb, r5_sb;
    logic [NBW-1:0]     r5_num1, r5_num2;
    logic [32:0]        r5_den;
    logic               is_two;

    assign sa     = r_sba[DA-1];
    assign sx     = signed'(SUMW'(sq));
    assign bx     = SUMW'(sa.b);
    assign t1     = sx - bx;
    assign t2     = -bx - sx;
    assign m1     = t1[SUMW-1] ? SUMW'(-t1) : SUMW'(t1);
    assign m2     = t2[SUMW-1] ? SUMW'(-t2) : SUMW'(t2);
    assign is_two = (sa.kind == qrs_pkg::K_TWO);

    always_comb begin
        n5_sb.kind = sa.kind;
        n5_sb.neg1 = is_two ? (t1[SUMW-1] ^ sa.a_neg) : sa.neg_pre;
        n5_sb.neg2 = is_two ? (t2[SUMW-1] ^ sa.a_neg) : sa.neg_pre;
        if (sq > SQW'(32'h7FFF_FFFF)) begin
            n5_sb.sym     = 32'h7FFF_FFFF;
            n5_sb.sym_ovf = 1'b1;
        end else begin
            n5_sb.sym     = sq[31:0];
            n5_sb.sym_ovf = 1'b0;
        end
        case (sa.kind)
            qrs_pkg::K_LIN,
            qrs_pkg::K_DBL: begin
                n5_m1 = SUMW'(sa.mpre);
                n5_m2 = '0;
            end
            qrs_pkg::K_CZ: begin
                n5_m1 = '0;
                n5_m2 = SUMW'(sa.mpre);
            end
            qrs_pkg::K_TWO: begin
                n5_m1 = m1;
                n5_m2 = m2;
            end
            default: begin
                n5_m1 = '0;
                n5_m2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sba[0] <= r4_sb;
            for (int i = 1; i < DA; i++) begin
                r_sba[i] <= r_sba[i-1];
            end
            r5_sb   <= n5_sb;
            r5_num1 <= NBW'(n5_m1) << F;
            r5_num2 <= NBW'(n5_m2) << F;
            r5_den  <= sa.den;
        end
    end

    logic [NBW-1:0] q1, q2;

    qrs_div #(.NUM_W(NBW), .DEN_W(33)) u_div_b1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num1),
        .i_den (r5_den),
        .o_quo (q1)
    );

    qrs_div #(.NUM_W(NBW), .DEN_W(33)) u_div_b2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num2),
        .i_den (r5_den),
        .o_quo (q2)
    );

    qrs_pkg::t_sbb r_sbb [NBW];

    // output: saturation and result selection
    function automatic logic [32:0] sat_root(input logic neg, input logic [NBW-1:0] m);
        logic [32:0] res;
        if (neg && m != '0) begin
            if (m > NBW'(32'h8000_0000)) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, ~m[31:0] + 32'd1};
            end
        end else if (m > NBW'(32'h7FFF_FFFF)) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else begin
            res = {1'b0, m[31:0]};
        end
        return res;
    endfunction

    qrs_pkg::t_sbb sb;
    logic [32:0]   p1, p2;
    qrs_pkg::t_cnt n_o_cnt, r_o_cnt;
    logic [31:0]   n_o_r1, n_o_r2, r_o_r1, r_o_r2;
    logic          n_o_ovf, r_o_ovf;

    assign sb = r_sbb[NBW-1];
    assign p1 = sat_root(sb.neg1, q1);
    assign p2 = sat_root(sb.neg2, q2);

    always_comb begin
        n_o_cnt = qrs_pkg::CNT_NONE;
        n_o_r1  = '0;
        n_o_r2  = '0;
        n_o_ovf = 1'b0;
        case (sb.kind)
            qrs_pkg::K_INF: n_o_cnt = qrs_pkg::CNT_INF;
            qrs_pkg::K_LIN,
            qrs_pkg::K_DBL: begin
                n_o_cnt = qrs_pkg::CNT_ONE;
                n_o_r1  = p1[31:0];
                n_o_ovf = p1[32];
            end
            qrs_pkg::K_CZ0: n_o_cnt = qrs_pkg::CNT_ONE;
            qrs_pkg::K_CZ: begin
                n_o_cnt = qrs_pkg::CNT_TWO;
                n_o_r2  = p2[31:0];
                n_o_ovf = p2[32];
            end
            qrs_pkg::K_SYM: begin
                n_o_cnt = qrs_pkg::CNT_TWO;
                n_o_r1  = sb.sym;
                n_o_r2  = ~sb.sym + 32'd1;
                n_o_ovf = sb.sym_ovf;
            end
            qrs_pkg::K_TWO: begin
                n_o_cnt = qrs_pkg::CNT_TWO;
                n_o_r1  = p1[31:0];
                n_o_r2  = p2[31:0];
                n_o_ovf = p1[32] | p2[32];
            end
            default: n_o_cnt = qrs_pkg::CNT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sbb[0] <= r5_sb;
            for (int i = 1; i < NBW; i++) begin
                r_sbb[i] <= r_sbb[i-1];
            end
            if (r_vld[TOT-1]) begin
                r_o_cnt <= n_o_cnt;
                r_o_r1  <= n_o_r1;
                r_o_r2  <= n_o_r2;
                r_o_ovf <= n_o_ovf;
            end
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {5'b0, r_o_ovf, r_o_r2, r_o_r1, r_o_cnt};

    a_empty_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && (r_o_cnt == qrs_pkg::CNT_NONE || r_o_cnt == qrs_pkg::CNT_INF)
        |-> r_o_r1 == '0 && r_o_r2 == '0 && !r_o_ovf)
        else $error("roots or overflow set without a finite root");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_cnt != qrs_pkg::CNT_TWO |-> r_o_r2 == '0)
        else $error("second root set with fewer than two roots");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_o_vld && !m_axis_tready && r_vld[TOT-1])
        else $error("input held off without a blocked result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && m_axis_tready && !r_vld[TOT-1] |=> !r_o_vld)
        else $error("taken result not retired");

endmodule

// File: tb/tb_quadratic_root_solver.sv
module tb_quadratic_root_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int LATENCY = 160;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  cnt;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        ovf;
    } t_roots;

    class root_board;
        t_roots pending[$];
        logic [15:0] eps;
        int errors;

        function new();
            eps = qrs_pkg::EPS_RESET;
            errors = 0;
        endfunction

        function bit is_small(logic signed [63:0] v);
            logic [63:0] m;
            m = v < 0 ? -v : v;
            return m == 0 || m < {48'd0, eps};
        endfunction

        function logic [31:0] sat(bit neg, logic [127:0] m, ref logic ovf);
            if (neg) begin
                if (m > 128'h80000000) begin
                    m = 128'h80000000;
                    ovf = 1;
                end
                return -m[31:0];
            end
            if (m > 128'h7fffffff) begin
                m = 128'h7fffffff;
                ovf = 1;
            end
            return m[31:0];
        endfunction

        function logic [31:0] quot(logic signed [63:0] num, logic signed [63:0] den,
                                   int scale, bit negate, ref logic ovf);
            logic [127:0] nm, dm, m;
            bit neg;
            nm = num < 0 ? -num : num;
            dm = den < 0 ? -den : den;
            m = (nm << FB) / (dm * scale);
            neg = ((num < 0) != (den < 0)) != negate;
            return sat(neg && m != 0, m, ovf);
        endfunction

        function logic [127:0] isqrt(logic [127:0] x);
            logic [127:0] r, c;
            r = 0;
            for (int i = 63; i >= 0; i--) begin
                c = r | (128'd1 << i);
                if (c * c <= x) r = c;
            end
            return r;
        endfunction

        function void note_coefs(logic signed [31:0] a32, logic signed [31:0] b32,
                                 logic signed [31:0] c32);
            t_roots e;
            logic signed [63:0] a, b, c, s;
            logic [127:0] ma, mc, bb, ac, dm, q;
            bit dneg;
            logic ovf;
            a = a32; b = b32; c = c32;
            e = '0;
            dneg = 0;
            ovf = 0;
            if (is_small(a)) begin
                if (!is_small(b)) begin
                    e.cnt = qrs_pkg::CNT_ONE;
                    e.r1 = quot(c, b, 1, 1, ovf);
                end else if (is_small(c)) begin
                    e.cnt = qrs_pkg::CNT_INF;
                end
            end else if (is_small(c)) begin
                e.cnt = b == 0 ? qrs_pkg::CNT_ONE : qrs_pkg::CNT_TWO;
                if (b != 0) e.r2 = quot(b, a, 1, 1, ovf);
            end else begin
                ma = a < 0 ? -a : a;
                mc = c < 0 ? -c : c;
                if (b == 0 && ((a < 0) != (c < 0))) begin
                    q = (mc << (2 * FB)) / ma;
                    e.cnt = qrs_pkg::CNT_TWO;
                    e.r1 = sat(0, isqrt(q), ovf);
                    e.r2 = -e.r1;
                end else begin
                    bb = (b < 0 ? -b : b);
                    bb = bb * bb;
                    ac = (ma * mc) << 2;
                    if ((a < 0) != (c < 0)) dm = bb + ac;
                    else if (ac <= bb) dm = bb - ac;
                    else begin
                        dm = ac - bb;
                        dneg = 1;
                    end
                    if (dm == 0 || dm < ({112'd0, eps} << FB)) begin
                        e.cnt = qrs_pkg::CNT_ONE;
                        e.r1 = quot(b, a, 2, 1, ovf);
                    end else if (!dneg) begin
                        s = 64'(isqrt(dm));
                        e.cnt = qrs_pkg::CNT_TWO;
                        e.r1 = quot(s - b, a, 2, 0, ovf);
                        e.r2 = quot(-b - s, a, 2, 0, ovf);
                    end
                end
            end
            e.ovf = ovf;
            pending.push_back(e);
        endfunction

        function void check_roots(t_roots got);
            t_roots e;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.cnt !== e.cnt) begin
                $error("root_count expected %0d got %0d", e.cnt, got.cnt);
                errors++;
            end
            if (got.r1 !== e.r1) begin
                $error("first_root expected %h got %h", e.r1, got.r1);
                errors++;
            end
            if (got.r2 !== e.r2) begin
                $error("second_root expected %h got %h", e.r2, got.r2);
                errors++;
            end
            if (got.ovf !== e.ovf) begin
                $error("overflow expected %0d got %0d", e.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    root_board board = new();
    int cycles = 0;
    int stall_mode = 0;

    quadratic_root_solver dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern, changes mode every so often
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_roots(t_roots'({m_axis_tdata[1:0], m_axis_tdata[33:2],
                                        m_axis_tdata[65:34], m_axis_tdata[66]}));
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (cycles % 5) != 0;
        endcase
    end

    task automatic write_eps(logic [15:0] v);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {16'd0, v}; penable <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.eps = v;
    endtask

    task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c, bit gap);
        if (gap) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {c, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_coefs(a, b, c);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return $urandom_range(0, 15) - 8;
            2: return 32'h80000000;
            3: return 32'h7fffffff;
            4: return ($urandom_range(0, 1) ? 32'h10000 : 32'hffff0000) * $urandom_range(1, 9);
            5, 6: return $urandom_range(0, 32'h7ffff) - 32'h40000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            logic [31:0] a, b, c;
            a = pick_coef(); b = pick_coef(); c = pick_coef();
            if ($urandom_range(0, 5) == 0) b = 0;
            if (burst == 0) burst = $urandom_range(1, 30);
            burst--;
            send_coefs(a, b, c, burst == 0 && $urandom_range(0, 3) != 0);
        end
        drain();
    endtask

    initial begin
        logic [15:0] eps_set[4];
        eps_set = '{16'd0, 16'hffff, 16'd1, 16'd300};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed corners with reset epsilon
        send_coefs(0, 0, 0, 0);
        send_coefs(0, 0, 32'h10000, 0);
        send_coefs(3, 2, 6, 0);
        send_coefs(0, 32'h20000, 32'h60000, 0);
        send_coefs(0, 1, 32'h7fffffff, 0);
        send_coefs(32'h10000, 32'h30000, 0, 0);
        send_coefs(32'h10000, 0, 0, 0);
        send_coefs(32'h10000, 0, 32'hfffc0000, 0);
        send_coefs(32'hffff0000, 0, 32'hfffc0000, 0);
        send_coefs(32'h10000, 0, 32'h40000, 0);
        send_coefs(32'h10000, 32'hfffe0000, 32'h10000, 0);
        send_coefs(32'h10000, 32'hfffd0000, 32'h20000, 0);
        send_coefs(32'h10000, 32'h10000, 32'h10000, 0);
        send_coefs(32'h80000000, 32'h80000000, 32'h80000000, 0);
        send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_coefs(32'h00000008, 32'h80000000, 32'h7fffffff, 0);
        send_coefs(32'h00000008, 0, 32'h80000000, 0);
        send_coefs(32'h80000000, 32'h7fffffff, 0, 0);
        send_coefs(32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        drain();
        random_phase(400);
        foreach (eps_set[k]) begin
            write_eps(eps_set[k]);
            send_coefs(0, 0, 0, 0);
            send_coefs(32'h10000, 32'h20000, 32'h10000, 0);
            random_phase(300);
        end
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: quadratic_root_solver.f
design/qrs_pkg.sv
design/qrs_div.sv
design/qrs_sqrt.sv
design/quadratic_root_solver.sv
tb/tb_quadratic_root_solver.sv
